// ===== rtl/ipp_pkg.sv =====
// Shared types, register codes and channel placement functions for the indexed pixel packer.
package ipp_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int QUEUE_DEPTH_DEF     = 4;
    localparam int MAX_ROW_WIDTH       = 4096;
    localparam int PAL_ENTRY_W         = 48;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 32;
    localparam int ROW_W               = 12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_DEPTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LSB_FIRST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RED_BITS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_BITS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_BITS   = 3'd5;

    // Output depth codes.
    localparam logic [2:0] DEPTH_1BIT  = 3'd0;
    localparam logic [2:0] DEPTH_2BIT  = 3'd1;
    localparam logic [2:0] DEPTH_4BIT  = 3'd2;
    localparam logic [2:0] DEPTH_8BIT  = 3'd3;
    localparam logic [2:0] DEPTH_16BIT = 3'd4;
    localparam logic [2:0] DEPTH_24BIT = 3'd5;

    typedef enum logic [1:0] {
        KIND_BYTES,
        KIND_RGB16,
        KIND_RGB24
    } kind_t;

    typedef logic signed [5:0] topbit_t;

    typedef struct packed {
        logic [2:0]       depth;
        logic [ROW_W-1:0] row_width;
        logic             lsb_first;
        logic [31:0]      red_bits;
        logic [31:0]      green_bits;
        logic [31:0]      blue_bits;
        topbit_t          red_top;
        topbit_t          green_top;
        topbit_t          blue_top;
    } cfg_t;

    // One queued job: bytes in send order from the low end, count of bytes, row end flag.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  count;
        logic        row_end;
    } job_t;

    // Highest set bit of a mask, -1 when the mask is zero.
    function automatic topbit_t top_bit(input logic [31:0] m);
        topbit_t t;
        t = -6'sd1;
        for (int i = 0; i < 32; i++) begin
            if (m[i]) begin
                t = 6'(i);
            end
        end
        return t;
    endfunction

    // 16-bit display: align the level's top bit with the mask's top bit, then mask.
    function automatic logic [15:0] chan16(input logic [15:0] level, input logic [31:0] mask,
                                           input topbit_t top);
        logic signed [6:0] s;
        logic [6:0]        mag;
        logic [31:0]       v;
        s   = 7'sd15 - $signed({top[5], top});
        mag = s[6] ? 7'(-s) : 7'(s);
        if (s[6]) begin
            v = {16'b0, level} << mag[4:0];
        end else begin
            v = {16'b0, level} >> mag[4:0];
        end
        return v[15:0] & mask[15:0];
    endfunction

    // 24-bit display: the level's upper byte placed so its top bit lands on the mask's top bit.
    function automatic logic [31:0] chan24(input logic [15:0] level, input topbit_t top);
        logic signed [6:0] s;
        logic [6:0]        mag;
        logic [31:0]       b;
        s   = $signed({top[5], top}) - 7'sd7;
        mag = s[6] ? 7'(-s) : 7'(s);
        b   = {24'b0, level[15:8]};
        if (s[6]) begin
            return b >> mag[4:0];
        end
        return b << mag[4:0];
    endfunction

    function automatic logic [ROW_W:0] eff_width(input logic [ROW_W-1:0] w);
        if (int'(w) > MAX_ROW_WIDTH) begin
            return (ROW_W+1)'(MAX_ROW_WIDTH);
        end
        return {1'b0, w};
    endfunction

endpackage

// ===== rtl/indexed_pixel_packer_core.sv =====
// Top level of the indexed pixel packer: configuration registers, front end, job queue, serializer.
//
// Load items (tuser 0) write one palette entry and produce nothing; convert items (tuser 1)
// produce the display bytes they complete, one byte per output transaction. The input side
// takes one item per cycle while the job queue has room. Bytes per pixel are set by the depth:
// 8-bit output gives 1 byte, 16-bit 2 bytes and 24-bit 4 bytes per pixel; 1, 2 and 4-bit output
// give a byte only when a pixel completes one, except that the pixel closing a row also carries
// the row padding, up to 5 bytes. A pixel's bytes pass the palette read and byte-forming step,
// then the job queue, then the output register, which the byte-wide serializer shifts out.
// Configuration writes to depth, width or bit order restart the row and drop a partial byte.
module indexed_pixel_packer_core #(
    parameter int PALETTE_ENTRIES = ipp_pkg::PALETTE_ENTRIES_DEF,
    parameter int QUEUE_DEPTH     = ipp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [55:0]                     s_tdata,   // pixel_index, red_level, green_level, blue_level
    input  logic                            s_tuser,   // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // out_byte
    output logic                            m_tlast,
    output logic                            m_tuser,   // row_done
    input  logic                            cfg_wr_en,
    input  logic [ipp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ipp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import ipp_pkg::*;

    localparam int LVL_W = $clog2(QUEUE_DEPTH+1);

    logic [2:0]       depth_reg, depth_next;
    logic [ROW_W-1:0] width_reg, width_next;
    logic             lsb_reg, lsb_next;
    logic [31:0]      red_bits_reg, red_bits_next;
    logic [31:0]      green_bits_reg, green_bits_next;
    logic [31:0]      blue_bits_reg, blue_bits_next;
    topbit_t          red_top_reg, red_top_next;
    topbit_t          green_top_reg, green_top_next;
    topbit_t          blue_top_reg, blue_top_next;

    cfg_t             cfg;
    logic             cfg_restart;
    logic             q_push;
    job_t             q_push_data;
    logic             q_pop;
    job_t             q_head;
    logic             q_empty;
    logic [LVL_W-1:0] q_level;

    always_comb begin
        depth_next      = depth_reg;
        width_next      = width_reg;
        lsb_next        = lsb_reg;
        red_bits_next   = red_bits_reg;
        green_bits_next = green_bits_reg;
        blue_bits_next  = blue_bits_reg;
        red_top_next    = red_top_reg;
        green_top_next  = green_top_reg;
        blue_top_next   = blue_top_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_PIXEL_DEPTH: begin
                    depth_next = cfg_wdata[2:0];
                end
                REG_ROW_WIDTH: begin
                    width_next = cfg_wdata[ROW_W-1:0];
                end
                REG_LSB_FIRST: begin
                    lsb_next = cfg_wdata[0];
                end
                REG_RED_BITS: begin
                    red_bits_next = cfg_wdata;
                    red_top_next  = top_bit(cfg_wdata);
                end
                REG_GREEN_BITS: begin
                    green_bits_next = cfg_wdata;
                    green_top_next  = top_bit(cfg_wdata);
                end
                REG_BLUE_BITS: begin
                    blue_bits_next = cfg_wdata;
                    blue_top_next  = top_bit(cfg_wdata);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg      <= DEPTH_8BIT;
            width_reg      <= ROW_W'(1);
            lsb_reg        <= 1'b0;
            red_bits_reg   <= 32'h0000_F800;
            green_bits_reg <= 32'h0000_07E0;
            blue_bits_reg  <= 32'h0000_001F;
            red_top_reg    <= 6'sd15;
            green_top_reg  <= 6'sd10;
            blue_top_reg   <= 6'sd4;
        end else begin
            depth_reg      <= depth_next;
            width_reg      <= width_next;
            lsb_reg        <= lsb_next;
            red_bits_reg   <= red_bits_next;
            green_bits_reg <= green_bits_next;
            blue_bits_reg  <= blue_bits_next;
            red_top_reg    <= red_top_next;
            green_top_reg  <= green_top_next;
            blue_top_reg   <= blue_top_next;
        end
    end

    assign cfg_restart = cfg_wr_en && (cfg_index == REG_PIXEL_DEPTH
                                    || cfg_index == REG_ROW_WIDTH
                                    || cfg_index == REG_LSB_FIRST);

    assign cfg.depth      = depth_reg;
    assign cfg.row_width  = width_reg;
    assign cfg.lsb_first  = lsb_reg;
    assign cfg.red_bits   = red_bits_reg;
    assign cfg.green_bits = green_bits_reg;
    assign cfg.blue_bits  = blue_bits_reg;
    assign cfg.red_top    = red_top_reg;
    assign cfg.green_top  = green_top_reg;
    assign cfg.blue_top   = blue_top_reg;

    ipp_front #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .QUEUE_DEPTH     (QUEUE_DEPTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg         (cfg),
        .cfg_restart (cfg_restart),
        .q_level     (q_level),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    ipp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_head),
        .empty     (q_empty),
        .level     (q_level)
    );

    ipp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // The input credit check must keep a slot free for every job the front end pushes.
    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (int'(q_level) < QUEUE_DEPTH))
        else $error("job queue pushed while full");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("job queue popped while empty");

    // Once the last byte of the last queued job leaves, the output goes idle.
    a_drain_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast && q_empty) |=> !m_tvalid)
        else $error("output stayed valid with no job queued");

endmodule

// ===== rtl/ipp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ipp_ram #(
    parameter int WIDTH = ipp_pkg::PAL_ENTRY_W,
    parameter int DEPTH = ipp_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ipp_front.sv =====
// Front end: accepts items, keeps the palette, packs low-depth pixels and builds byte jobs.
module ipp_front #(
    parameter int PALETTE_ENTRIES = ipp_pkg::PALETTE_ENTRIES_DEF,
    parameter int QUEUE_DEPTH     = ipp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [55:0]                        s_tdata,
    input  logic                               s_tuser,
    input  ipp_pkg::cfg_t                      cfg,
    input  logic                               cfg_restart,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_level,
    output logic                               q_push,
    output ipp_pkg::job_t                      q_push_data
);

    import ipp_pkg::*;

    localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

    logic                   accept;
    logic [7:0]             idx;
    logic                   in_range;
    logic                   conv_ok;
    logic                   low;
    logic [3:0]             d;
    logic [7:0]             v8;
    logic [2:0]             sh;
    logic [7:0]             acc_new;
    logic [3:0]             bp_sum;
    logic                   pix_emit;
    logic [7:0]             acc_mid;
    logic [2:0]             bp_mid;
    logic [ROW_W:0]         col_sum;
    logic                   row_end;
    logic [3:0]             pad;
    logic [5:0]             pad_bits;
    logic [5:0]             total;
    logic [2:0]             npad;
    logic [7:0]             acc_fin;
    logic [2:0]             bp_fin;
    kind_t                  kind;
    logic [7:0]             byte0;
    logic [2:0]             count;

    logic [7:0]             acc_reg, acc_next;
    logic [2:0]             bp_reg, bp_next;
    logic [ROW_W-1:0]       col_reg, col_next;

    logic                   s2_valid_reg;
    kind_t                  s2_kind_reg;
    logic [7:0]             s2_byte_reg;
    logic [2:0]             s2_count_reg;
    logic                   s2_row_reg;
    logic                   s2_hit_reg;
    logic                   s2_job;

    logic [PAL_ENTRY_W-1:0] pal_rd;
    logic [PAL_ENTRY_W-1:0] pal;
    logic [15:0]            t16;
    logic [31:0]            c24;
    logic [31:0]            word;

    assign accept   = s_tvalid && s_tready;
    assign idx      = s_tdata[7:0];
    assign in_range = int'(idx) < PALETTE_ENTRIES;
    assign s2_job   = s2_valid_reg && (s2_count_reg != 3'd0);
    // Every job in flight downstream of acceptance already owns a queue slot.
    assign s_tready = (int'(q_level) + int'(s2_job)) < QUEUE_DEPTH;

    ipp_ram #(
        .WIDTH (PAL_ENTRY_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk     (aclk),
        .wr_en   (accept && !s_tuser && in_range),
        .wr_addr (idx[PAL_AW-1:0]),
        .wr_data (s_tdata[55:8]),
        .rd_en   (accept && s_tuser),
        .rd_addr (idx[PAL_AW-1:0]),
        .rd_data (pal_rd)
    );

    always_comb begin
        conv_ok = 1'b1;
        low     = 1'b0;
        kind    = KIND_BYTES;
        byte0   = idx;
        count   = 3'd0;
        case (cfg.depth)
            DEPTH_1BIT, DEPTH_2BIT, DEPTH_4BIT: begin
                low = 1'b1;
            end
            DEPTH_8BIT: begin
                count = 3'd1;
            end
            DEPTH_16BIT: begin
                kind  = KIND_RGB16;
                count = 3'd2;
            end
            DEPTH_24BIT: begin
                kind  = KIND_RGB24;
                count = 3'd4;
            end
            default: begin
                conv_ok = 1'b0;
            end
        endcase

        // Place the masked index into the partial byte.
        d        = 4'd1 << cfg.depth[1:0];
        v8       = idx & 8'((9'd1 << d) - 9'd1);
        sh       = cfg.lsb_first ? bp_reg : 3'(4'd8 - d - {1'b0, bp_reg});
        acc_new  = acc_reg | (v8 << sh);
        bp_sum   = {1'b0, bp_reg} + d;
        pix_emit = bp_sum[3];
        acc_mid  = pix_emit ? 8'd0 : acc_new;
        bp_mid   = pix_emit ? 3'd0 : bp_sum[2:0];

        col_sum  = {1'b0, col_reg} + (ROW_W+1)'(1);
        row_end  = col_sum >= eff_width(cfg.row_width);

        // Row padding in blank pixels; the first padded byte is the partial byte, the rest zero.
        pad      = 4'd8 - {1'b0, col_sum[2:0]};
        pad_bits = 6'(pad) << cfg.depth[1:0];
        total    = {3'b0, bp_mid} + pad_bits;
        npad     = row_end ? total[5:3] : 3'd0;
        bp_fin   = row_end ? total[2:0] : bp_mid;
        acc_fin  = (npad != 3'd0) ? 8'd0 : acc_mid;

        if (low) begin
            byte0 = acc_new;
            count = {2'b0, pix_emit} + npad;
        end

        acc_next = acc_reg;
        bp_next  = bp_reg;
        col_next = col_reg;
        if (cfg_restart) begin
            acc_next = '0;
            bp_next  = '0;
            col_next = '0;
        end else if (accept && s_tuser && conv_ok) begin
            col_next = row_end ? '0 : col_sum[ROW_W-1:0];
            if (low) begin
                acc_next = acc_fin;
                bp_next  = bp_fin;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            bp_reg       <= '0;
            col_reg      <= '0;
            s2_valid_reg <= 1'b0;
        end else begin
            acc_reg      <= acc_next;
            bp_reg       <= bp_next;
            col_reg      <= col_next;
            s2_valid_reg <= accept && s_tuser && conv_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s2_kind_reg  <= kind;
            s2_byte_reg  <= byte0;
            s2_count_reg <= count;
            s2_row_reg   <= row_end;
            s2_hit_reg   <= in_range;
        end
    end

    // Second step: palette data is here, form the bytes in send order.
    always_comb begin
        pal = s2_hit_reg ? pal_rd : '0;
        t16 = chan16(pal[15:0], cfg.red_bits, cfg.red_top)
            | chan16(pal[31:16], cfg.green_bits, cfg.green_top)
            | chan16(pal[47:32], cfg.blue_bits, cfg.blue_top);
        c24 = chan24(pal[15:0], cfg.red_top)
            | chan24(pal[31:16], cfg.green_top)
            | chan24(pal[47:32], cfg.blue_top);
        case (s2_kind_reg)
            KIND_BYTES: begin
                word = {24'b0, s2_byte_reg};
            end
            KIND_RGB16: begin
                word = cfg.lsb_first ? {16'b0, t16} : {16'b0, t16[7:0], t16[15:8]};
            end
            KIND_RGB24: begin
                word = cfg.lsb_first ? c24 : {c24[7:0], c24[15:8], c24[23:16], c24[31:24]};
            end
            default: begin
                word = '0;
            end
        endcase
    end

    assign q_push              = s2_job;
    assign q_push_data.word    = word;
    assign q_push_data.count   = s2_count_reg;
    assign q_push_data.row_end = s2_row_reg;

endmodule

// ===== rtl/ipp_queue.sv =====
// Short job queue between the front end and the byte serializer.
module ipp_queue #(
    parameter int DEPTH = ipp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  ipp_pkg::job_t                push_data,
    input  logic                         pop,
    output ipp_pkg::job_t                pop_data,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   level
);

    import ipp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH+1);

    job_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = (int'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (int'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            level_next = level_reg + LVL_W'(1);
        end else if (pop && !push) begin
            level_next = level_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = entries_reg[rd_ptr_reg];
    assign empty    = (level_reg == '0);
    assign level    = level_reg;

endmodule

// ===== rtl/ipp_back.sv =====
// Back end: shifts queued jobs out one byte per transaction through the output register.
module ipp_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    input  ipp_pkg::job_t q_head,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tlast,
    output logic          m_tuser
);

    import ipp_pkg::*;

    logic [31:0] word_reg, word_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        row_reg, row_next;
    logic        fire;
    logic        finishing;

    always_comb begin
        fire      = m_tvalid && m_tready;
        finishing = !m_tvalid || (fire && cnt_reg == 3'd1);
        q_pop     = finishing && !q_empty;

        word_next = word_reg;
        cnt_next  = cnt_reg;
        row_next  = row_reg;
        if (q_pop) begin
            word_next = q_head.word;
            cnt_next  = q_head.count;
            row_next  = q_head.row_end;
        end else if (fire) begin
            word_next = word_reg >> 8;
            cnt_next  = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        row_reg  <= row_next;
    end

    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tdata  = word_reg[7:0];
    assign m_tlast  = (cnt_reg == 3'd1);
    assign m_tuser  = row_reg && (cnt_reg == 3'd1);

endmodule
